FILE: hdl/trd_pkg.sv
// trd_pkg: shared types and constants for the TGA run-length decoder.
// No dependencies; used by the interfaces and every decoder module.
package trd_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 32;
  localparam int RCNT_W     = 8;
  localparam int BPP_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int BIDX_W     = 2;

  localparam logic [BYTE_W-1:0] RUN_BASE   = 8'd127;  // run length = header - 127
  localparam logic [BPP_W-1:0]  BPP_MAX    = 3'd4;
  localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd3;
  localparam logic [CFG_DATA_W-1:0] PCOUNT_RESET = 25'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP         = 2'd0,
    REG_PIXEL_COUNT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_value;
    logic [RCNT_W-1:0] repeat_count;
    logic              image_done;
    logic              overrun_error;
  } result_t;

endpackage

FILE: hdl/trd_if.sv
// trd_if: valid/ready channels of the decoder (byte in, pixel out, config write).
// Depends on trd_pkg.
interface trd_byte_if import trd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface trd_pix_if import trd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_value;
  logic [RCNT_W-1:0] repeat_count;
  logic              image_done;
  logic              overrun_error;

  modport source (output valid, output pixel_value, output repeat_count,
                  output image_done, output overrun_error, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input image_done, input overrun_error, output ready);
endinterface

interface trd_cfg_if import trd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tga_rle_decoder_unit.sv
// tga_rle_decoder_unit: TGA run-length pixel stream decoder, one byte per word.
// Each result is registered into the output register, or into the skid entry while that register is held.
// Throughput: one byte per cycle while the skid entry is empty; a held skid entry stalls the input.
// Results: one per pixel (one per run packet); header and partial-pixel bytes give none.
// Reset (rst, synchronous): header phase, counters cleared, bytes_per_pixel = 3,
// pixel_count = 1, output and skid entries empty.
module tga_rle_decoder_unit import trd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input logic        clk,
  input logic        rst,
  trd_byte_if.sink   byte_ch,
  trd_pix_if.source  pix_ch,
  trd_cfg_if.sink    cfg_ch
);
  // Effective config, already clamped (0 -> 1, too large -> max).
  logic [BPP_W-1:0]    bpp;
  logic [COUNT_BITS:0] total;

  // Decoder result for the byte on the input this cycle.
  logic    res_valid;
  result_t res;
  logic    buf_full;
  logic    byte_fire;

  // Input stalls only when both output register and skid entry hold results,
  // so a waiting result never blocks the next byte by itself.
  assign byte_ch.ready = !buf_full;
  assign byte_fire     = byte_ch.valid && byte_ch.ready;

  trd_cfg_regs #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .bpp   (bpp),
    .total (total)
  );

  // Per-byte state: header decode, pixel assembly, image count and clipping.
  trd_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .fire      (byte_fire),
    .byte_in   (byte_ch.byte_in),
    .bpp       (bpp),
    .total     (total),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register with a skid word toward the pixel channel.
  trd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .pix       (pix_ch)
  );

endmodule

FILE: hdl/trd_cfg_regs.sv
// trd_cfg_regs: bytes-per-pixel and pixel-count registers, clamped to legal range.
// Depends on trd_pkg and trd_cfg_if.
module trd_cfg_regs import trd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  trd_cfg_if.sink             cfg,
  output logic [BPP_W-1:0]    bpp,
  output logic [COUNT_BITS:0] total
);
  localparam int CW = COUNT_BITS + 1;
  localparam int WW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam logic [WW-1:0] LIM = WW'(1) << COUNT_BITS;

  logic [BPP_W-1:0]      bpp_reg;
  logic [CFG_DATA_W-1:0] pcount_reg;
  logic [WW-1:0]         pc_ext;
  logic [WW-1:0]         total_w;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_reg    <= BPP_RESET;
      pcount_reg <= PCOUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BPP:         bpp_reg    <= cfg.data[BPP_W-1:0];
        REG_PIXEL_COUNT: pcount_reg <= cfg.data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_comb begin
    if (bpp_reg == '0)         bpp = 3'd1;
    else if (bpp_reg > BPP_MAX) bpp = BPP_MAX;
    else                       bpp = bpp_reg;

    pc_ext = WW'(pcount_reg);
    if (pc_ext == '0)      total_w = WW'(1);
    else if (pc_ext > LIM) total_w = LIM;
    else                   total_w = pc_ext;
    total = total_w[CW-1:0];
  end

endmodule

FILE: hdl/trd_decode.sv
// trd_decode: packet/pixel state and per-byte result generation.
// Depends on trd_pkg.
module trd_decode import trd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic [BPP_W-1:0]    bpp,
  input  logic [COUNT_BITS:0] total,
  output logic                res_valid,
  output result_t             res
);
  localparam int CW = COUNT_BITS + 1;

  phase_t            phase, phase_next;
  logic              run_packet, run_packet_next;
  logic [7:0]        packet_left, packet_left_next;
  logic [BIDX_W-1:0] byte_index, byte_index_next;
  logic [PIX_W-1:0]  pixel_accum, pixel_accum_next;
  logic [CW-1:0]     pixels_done, pixels_done_next;

  logic [PIX_W-1:0]  accum_new;
  logic              last_byte;
  logic [CW-1:0]     remaining, pl_ext, count;
  logic [7:0]        pl_dec;
  logic              done, over;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      run_packet  <= 1'b0;
      packet_left <= '0;
      byte_index  <= '0;
      pixel_accum <= '0;
      pixels_done <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      run_packet  <= run_packet_next;
      packet_left <= packet_left_next;
      byte_index  <= byte_index_next;
      pixel_accum <= pixel_accum_next;
      pixels_done <= pixels_done_next;
    end
  end

  always_comb begin
    accum_new = pixel_accum | (PIX_W'(byte_in) << {byte_index, 3'b000});
    last_byte = ({1'b0, byte_index} + 3'd1) >= bpp;
    remaining = (pixels_done < total) ? (total - pixels_done) : CW'(1);
    pl_ext    = CW'(packet_left);
    pl_dec    = (packet_left != '0) ? packet_left - 8'd1 : 8'd0;

    if (run_packet) begin
      over  = pl_ext > remaining;
      count = over ? remaining : pl_ext;
    end else begin
      count = CW'(1);
      over  = (remaining == CW'(1)) && (pl_dec != '0);
    end
    done = count >= remaining;

    phase_next       = phase;
    run_packet_next  = run_packet;
    packet_left_next = packet_left;
    byte_index_next  = byte_index;
    pixel_accum_next = pixel_accum;
    pixels_done_next = pixels_done;
    res_valid        = 1'b0;

    case (phase)
      PH_PIXEL: begin
        if (!last_byte) begin
          pixel_accum_next = accum_new;
          byte_index_next  = byte_index + BIDX_W'(1);
        end else begin
          res_valid        = fire;
          pixel_accum_next = '0;
          byte_index_next  = '0;
          packet_left_next = run_packet ? 8'd0 : pl_dec;
          if (done) begin
            pixels_done_next = '0;
            packet_left_next = '0;
          end else begin
            pixels_done_next = pixels_done + count;
          end
          if (packet_left_next == '0) phase_next = PH_HEADER;
        end
      end
      default: begin
        // header byte: bit 7 selects run vs raw
        run_packet_next  = byte_in[7];
        packet_left_next = byte_in[7] ? byte_in - RUN_BASE : byte_in + 8'd1;
        byte_index_next  = '0;
        pixel_accum_next = '0;
        phase_next       = PH_PIXEL;
      end
    endcase

    res.pixel_value   = accum_new;
    res.repeat_count  = count[RCNT_W-1:0];
    res.image_done    = done;
    res.overrun_error = over;
  end

endmodule

FILE: hdl/trd_out_buf.sv
// trd_out_buf: result register plus skid entry in front of the pixel channel.
// Depends on trd_pkg and trd_pix_if.
module trd_out_buf import trd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  trd_pix_if.source pix
);
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    pop;

  assign pop  = out_valid && pix.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) out_valid  <= 1'b1;
      else            skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) out_data <= skid_data;
      else if (push)  out_data <= push_data;
    end else if (push) begin
      if (!out_valid) out_data  <= push_data;
      else            skid_data <= push_data;
    end
  end

  assign pix.valid         = out_valid;
  assign pix.pixel_value   = out_data.pixel_value;
  assign pix.repeat_count  = out_data.repeat_count;
  assign pix.image_done    = out_data.image_done;
  assign pix.overrun_error = out_data.overrun_error;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_over_ends_image: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overrun_error) |-> out_data.image_done)
    else $error("overrun reported without image end");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.repeat_count != '0))
    else $error("result with zero repeat count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid)
    else $error("skid entry lost while stalled");

endmodule

FILE: verif/tga_rle_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tga_rle_decoder_unit: a behavioral decoder predicts each
// pixel word, randomized valid/ready gaps and one long output stall stress the handshakes.
// Depends on trd_pkg and the trd_*_if channel interfaces.
module tga_rle_decoder_unit_tb;
  import trd_pkg::*;

  localparam int unsigned RAND_BYTES = 450;
  localparam int unsigned IDLE_WAIT  = 4;     // cycles after last result before a reg write
  localparam int unsigned DRAIN_MAX  = 20000;
  localparam int unsigned STALL_LEN  = 300;   // long output hold-off
  localparam int unsigned MAX_PIXELS = 1 << 24;
  localparam int          BPP_PAD_W  = CFG_DATA_W - BPP_W;  // unused bits above bpp
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;  // unmapped register slots
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [BYTE_W-1:0] HDR_RAW_MIN = 8'h00;  // raw, one pixel
  localparam logic [BYTE_W-1:0] HDR_RAW_MAX = 8'h7F;  // raw, 128 pixels
  localparam logic [BYTE_W-1:0] HDR_RUN_MIN = 8'h80;  // run of one
  localparam logic [BYTE_W-1:0] HDR_RUN_MAX = 8'hFF;  // run of 128

  logic clk;
  logic rst;

  trd_byte_if byte_ch ();
  trd_pix_if  pix_ch ();
  trd_cfg_if  cfg_ch ();

  tga_rle_decoder_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .pix_ch  (pix_ch),
    .cfg_ch  (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Decoder model state: registers plus packet / pixel / image progress.
  // ---------------------------------------------------------------------------
  logic [BPP_W-1:0]      cfg_bpp   = BPP_RESET;
  logic [CFG_DATA_W-1:0] cfg_count = PCOUNT_RESET;
  phase_t                dec_phase = PH_HEADER;
  bit                    dec_run   = 1'b0;
  logic [RCNT_W-1:0]     pkt_left  = '0;
  logic [BIDX_W-1:0]     byte_idx  = '0;
  logic [PIX_W-1:0]      pix_acc   = '0;
  int unsigned           img_pixels = 0;

  result_t pending_pixels[$];   // expected pixel words, oldest first
  int unsigned err_cnt    = 0;
  int unsigned bytes_sent = 0;
  bit          fast_mode  = 1'b0;  // sender offers back to back
  int unsigned stall_reqs = 0;     // bumped to request one long output stall

  // Out-of-range bpp folds into 1..4.
  function automatic int unsigned eff_bpp(input logic [BPP_W-1:0] bpp);
    if (bpp == 0) return 1;
    if (bpp > BPP_MAX) return 32'(BPP_MAX);
    return 32'(bpp);
  endfunction

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_BPP:         cfg_bpp = val[BPP_W-1:0];
      REG_PIXEL_COUNT: cfg_count = val;
      default: ;  // unmapped slot, write dropped
    endcase
  endtask

  // Advance the decoder by one stream byte; got is set when a pixel word comes out.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit got, output result_t r);
    int unsigned total;
    int unsigned remaining;
    int unsigned cnt;
    bit          over;
    bit          fin;
    got = 1'b0;
    r   = '0;
    if (dec_phase != PH_PIXEL) begin
      // packet header
      dec_run   = b[7];
      pkt_left  = b[7] ? b - RUN_BASE : b + 8'd1;
      dec_phase = PH_PIXEL;
      byte_idx  = '0;
      pix_acc   = '0;
      return;
    end
    pix_acc = pix_acc | (PIX_W'(b) << (8 * byte_idx));
    if (int'(byte_idx) + 1 < eff_bpp(cfg_bpp)) begin
      byte_idx = byte_idx + BIDX_W'(1);
      return;
    end
    r.pixel_value = pix_acc;
    byte_idx = '0;
    pix_acc  = '0;

    if (cfg_count == 0) total = 1;
    else if (cfg_count > MAX_PIXELS) total = MAX_PIXELS;
    else total = 32'(cfg_count);
    remaining = (img_pixels < total) ? total - img_pixels : 1;

    if (dec_run) begin
      cnt  = 32'(pkt_left);
      over = 1'b0;
      if (cnt > remaining) begin
        cnt  = remaining;
        over = 1'b1;
      end
      pkt_left = '0;
    end else begin
      cnt      = 1;
      pkt_left = (pkt_left > 0) ? pkt_left - 8'd1 : '0;
      over     = (remaining == 1) && (pkt_left > 0);
    end

    fin = (cnt >= remaining);
    if (fin) begin
      img_pixels = 0;
      pkt_left   = '0;
    end else begin
      img_pixels = img_pixels + cnt;
    end
    if (pkt_left == 0) dec_phase = PH_HEADER;

    r.repeat_count  = cnt[RCNT_W-1:0];
    r.image_done    = fin;
    r.overrun_error = over;
    got = 1'b1;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side ready: bursts of ready with random gaps; one long hold-off on
  // request, counted here so the sender keeps pushing into a full block.
  // ---------------------------------------------------------------------------
  initial begin : out_ready
    int unsigned stall_seen;
    int unsigned gap;
    stall_seen = 0;
    pix_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        pix_ch.ready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
      end else begin
        pix_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          pix_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake monitor. Register writes and accepted bytes feed the model;
  // each accepted pixel word is checked against the oldest expectation.
  // Input side is handled first so a combinational result would still line up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    result_t want;
    result_t seen;
    bit      got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg_write(cfg_ch.index, cfg_ch.data);
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.byte_in, got, want);
        if (got) pending_pixels.push_back(want);
      end
      if (pix_ch.valid && pix_ch.ready) begin
        seen.pixel_value   = pix_ch.pixel_value;
        seen.repeat_count  = pix_ch.repeat_count;
        seen.image_done    = pix_ch.image_done;
        seen.overrun_error = pix_ch.overrun_error;
        if (pending_pixels.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected pixel word value %h count %0d done %b over %b",
                     $realtime, seen.pixel_value, seen.repeat_count, seen.image_done,
                     seen.overrun_error);
        end else begin
          want = pending_pixels.pop_front();
          if (seen.pixel_value !== want.pixel_value || seen.repeat_count !== want.repeat_count
              || seen.image_done !== want.image_done
              || seen.overrun_error !== want.overrun_error) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: pixel mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime,
                       want.pixel_value, want.repeat_count, want.image_done,
                       want.overrun_error, seen.pixel_value, seen.repeat_count,
                       seen.image_done, seen.overrun_error);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one byte; valid stays high on return so back-to-back words never
  // drop it within a step.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = fast_mode ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Block idle: input parked, every expected word out, plus latency slack for
  // bytes that never produce a word.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Well-formed packet with random pixel content; mostly short lengths.
  task automatic send_packet(input int unsigned bpp);
    logic [BYTE_W-1:0] hdr;
    int unsigned       r;
    int unsigned       npix;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: hdr = HDR_RAW_MIN;
        1: hdr = HDR_RAW_MAX;
        2: hdr = HDR_RUN_MIN;
        default: hdr = HDR_RUN_MAX;
      endcase
    end else if (r < 14) begin
      hdr = BYTE_W'($urandom_range(8, 40));
    end else if (r < 55) begin
      hdr = BYTE_W'($urandom_range(0, 7));
    end else begin
      hdr = HDR_RUN_MIN + BYTE_W'($urandom_range(0, 127));
    end
    npix = hdr[7] ? 1 : hdr + 1;
    send_byte(hdr);
    repeat (npix * bpp) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: 3-byte pixels, single-pixel image.
  task automatic test_reset_defaults();
    // raw packet ends with the image
    send_byte(HDR_RAW_MIN);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
    // two-pixel raw packet into a one-pixel image: overrun, rest dropped
    send_byte(8'h01);
    send_byte(8'hAA); send_byte(8'hBB); send_byte(8'hCC);
  endtask

  // Longest run clipped to a 4-pixel image, all-ones pixel.
  task automatic test_run_clip();
    write_reg(REG_BPP, CFG_DATA_W'(4));
    write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(4));
    send_byte(HDR_RUN_MAX);
    repeat (4) send_byte(8'hFF);
  endtask

  // Image size dropped to no more than the pixels already decoded; zero bpp and count fold to 1.
  task automatic test_count_lowered();
    write_reg(REG_BPP, '0);
    write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(3));
    send_byte(HDR_RUN_MIN);
    send_byte(8'h00);
    write_reg(REG_PIXEL_COUNT, '0);
    send_byte(8'h85);
    send_byte(8'h80);
  endtask

  // bpp 7 acts as 4, then dropped to 1 mid pixel; oversize count; spare slots ignored.
  task automatic test_bpp_lowered();
    write_reg(REG_BPP, CFG_DATA_W'(7));
    write_reg(REG_PIXEL_COUNT, '1);
    send_byte(HDR_RAW_MIN);
    send_byte(8'h01); send_byte(8'h02);
    write_reg(REG_BPP, CFG_DATA_W'(1));
    send_byte(8'h03);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    send_byte(HDR_RUN_MIN);
    send_byte(8'h7E);
  endtask

  // Output held off long while a 128-pixel raw packet streams in back to back.
  task automatic test_backpressure();
    write_reg(REG_BPP, CFG_DATA_W'(1));
    write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(1000));
    fast_mode = 1'b1;
    stall_reqs++;
    send_byte(HDR_RAW_MAX);
    repeat (128) send_byte(BYTE_W'($urandom_range(0, 255)));
    fast_mode = 1'b0;
  endtask

  // Phases of random settings; mostly well-formed packets, some raw noise.
  // Writes land anywhere in an image or pixel, so lowering mid-image happens too.
  task automatic test_random_stream();
    int unsigned       stop_at;
    int unsigned       target;
    int unsigned       cur_bpp;
    int unsigned       r;
    logic [BPP_W-1:0]  bpp_val;
    logic [CFG_DATA_W-1:0] cnt_val;
    stop_at = bytes_sent + RAND_BYTES;
    cur_bpp = eff_bpp(cfg_bpp);
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 1) == 0) begin
        bpp_val = ($urandom_range(0, 9) < 8) ? BPP_W'($urandom_range(1, 4))
                                              : BPP_W'($urandom_range(0, 7));
        // upper data bits are don't-care for this register
        write_reg(REG_BPP, {BPP_PAD_W'($urandom_range(0, (1 << BPP_PAD_W) - 1)), bpp_val});
        cur_bpp = eff_bpp(bpp_val);
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 60) cnt_val = CFG_DATA_W'($urandom_range(1, 40));
        else if (r < 80) cnt_val = CFG_DATA_W'($urandom_range(41, 400));
        else if (r < 85) cnt_val = '0;
        else if (r < 90) cnt_val = CFG_DATA_W'(MAX_PIXELS);
        else if (r < 95)
          cnt_val = CFG_DATA_W'($urandom_range(MAX_PIXELS + 1, (1 << CFG_DATA_W) - 1));
        else cnt_val = CFG_DATA_W'($urandom);
        write_reg(REG_PIXEL_COUNT, cnt_val);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
      fast_mode = ($urandom_range(0, 3) == 0);
      target = bytes_sent + $urandom_range(20, 100);
      while (bytes_sent < target) begin
        if ($urandom_range(0, 99) < 85) send_packet(cur_bpp);
        else repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
      fast_mode = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned waited;
    rst             = 1'b1;
    byte_ch.valid   <= 1'b0;
    byte_ch.byte_in <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_run_clip();
    test_count_lowered();
    test_bpp_lowered();
    test_backpressure();
    test_random_stream();

    // drain, then allow for the output latency
    byte_ch.valid <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/trd_pkg.sv
hdl/trd_if.sv
hdl/trd_cfg_regs.sv
hdl/trd_decode.sv
hdl/trd_out_buf.sv
hdl/tga_rle_decoder_unit.sv
verif/tga_rle_decoder_unit_tb.sv
